// ===== sv/unique_host_counter_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// unique host counter table assertion macros
// shared property templates for the host table checks
// ----------------------------------------------------------------------------
`ifndef UNIQUE_HOST_COUNTER_TABLE_TOP_DEFINES_SVH
`define UNIQUE_HOST_COUNTER_TABLE_TOP_DEFINES_SVH

// same-cycle implication under the block reset
`define UHCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under the block reset
`define UHCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/uhct_pkg.sv =====
// ----------------------------------------------------------------------------
// uhct_pkg
// sizes and helpers for the host table with per-entry counters
// ----------------------------------------------------------------------------
package uhct_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 32;
    localparam int OIDX_W  = 8;
    localparam int OFILL_W = 9;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

    typedef logic [CNT_W-1:0] cnt_t;

    // saturating counter add
    function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
        logic [CNT_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        end
    endfunction

endpackage

// ===== sv/unique_host_counter_table_top.sv =====
// ----------------------------------------------------------------------------
// unique_host_counter_table_top
// host table keyed by ip and mac with saturating per-entry and total counters
// ----------------------------------------------------------------------------
// from start to done the linear search reads one table entry per cycle from the
// key memory, then one shared saturating adder takes four steps (two, for the
// totals only, when the table is full and the host is new) and a result state follows
// a new packet is taken only once the last one is done; busy is high throughout
// reset clears fill count, totals and sequencer; table memories are not cleared
// the result is shown for one cycle on done and cannot be held off
`include "unique_host_counter_table_top_defines.svh"

module unique_host_counter_table_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [uhct_pkg::IP_W-1:0]     ip_address,
    input  logic [uhct_pkg::MAC_W-1:0]    mac_address,
    input  logic [uhct_pkg::LEN_W-1:0]    frame_length,
    output logic                          done,
    output logic [uhct_pkg::OIDX_W-1:0]   entry_index,
    output logic                          was_new,
    output logic                          table_full,
    output logic [uhct_pkg::CNT_W-1:0]    entry_packets,
    output logic [uhct_pkg::CNT_W-1:0]    entry_bytes,
    output logic [uhct_pkg::OFILL_W-1:0]  hosts_seen,
    output logic [uhct_pkg::CNT_W-1:0]    packets_seen,
    output logic [uhct_pkg::CNT_W-1:0]    bytes_seen
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_APKT   = 3'd2;
    localparam logic [2:0] ST_ABYTE  = 3'd3;
    localparam logic [2:0] ST_TPKT   = 3'd4;
    localparam logic [2:0] ST_TBYTE  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // table memories
    logic [uhct_pkg::IP_W-1:0]  ip_mem   [uhct_pkg::TABLE_DEPTH];
    logic [uhct_pkg::MAC_W-1:0] mac_mem  [uhct_pkg::TABLE_DEPTH];
    uhct_pkg::cnt_t             pkt_mem  [uhct_pkg::TABLE_DEPTH];
    uhct_pkg::cnt_t             byte_mem [uhct_pkg::TABLE_DEPTH];

    logic [uhct_pkg::IP_W-1:0]  ip_q;
    logic [uhct_pkg::MAC_W-1:0] mac_q;
    uhct_pkg::cnt_t             pkt_q;
    uhct_pkg::cnt_t             byte_q;

    logic [2:0]                  state_reg, state_next;
    logic [uhct_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [uhct_pkg::FILL_W-1:0] scan_reg, scan_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic [uhct_pkg::IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    uhct_pkg::cnt_t              tpkt_reg, tpkt_next;
    uhct_pkg::cnt_t              tbyte_reg, tbyte_next;

    logic [uhct_pkg::IP_W-1:0]   key_ip_reg;
    logic [uhct_pkg::MAC_W-1:0]  key_mac_reg;
    logic [uhct_pkg::LEN_W-1:0]  len_reg;
    logic [uhct_pkg::IDX_W-1:0]  slot_reg, slot_next;
    logic                        new_reg, new_next;
    logic                        full_reg, full_next;
    uhct_pkg::cnt_t              pk_reg, pk_next;
    uhct_pkg::cnt_t              by_reg, by_next;

    logic                        accept;
    logic                        rd_en;
    logic                        key_match;
    logic                        key_we;
    logic                        cnt_we;
    uhct_pkg::cnt_t              add_a;
    uhct_pkg::cnt_t              add_b;
    uhct_pkg::cnt_t              add_sum;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign key_match = (ip_q == key_ip_reg) && (mac_q == key_mac_reg);

    // the one shared saturating adder
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            ST_APKT:
            begin
                add_a = new_reg ? '0 : pkt_q;
                add_b = uhct_pkg::cnt_t'(1);
            end
            ST_ABYTE:
            begin
                add_a = new_reg ? '0 : byte_q;
                add_b = uhct_pkg::cnt_t'(len_reg);
            end
            ST_TPKT:
            begin
                add_a = tpkt_reg;
                add_b = uhct_pkg::cnt_t'(1);
            end
            ST_TBYTE:
            begin
                add_a = tbyte_reg;
                add_b = uhct_pkg::cnt_t'(len_reg);
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum = uhct_pkg::sat_add(add_a, add_b);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        scan_next     = scan_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        tpkt_next     = tpkt_reg;
        tbyte_next    = tbyte_reg;
        slot_next     = slot_reg;
        new_next      = new_reg;
        full_next     = full_reg;
        pk_next       = pk_reg;
        by_next       = by_reg;
        rd_en         = 1'b0;
        key_we        = 1'b0;
        cnt_we        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEARCH;
                    scan_next  = '0;
                    new_next   = 1'b0;
                    full_next  = 1'b0;
                end
            end
            ST_SEARCH:
            begin
                if (rd_valid_reg && key_match)
                begin
                    slot_next  = rd_idx_reg;
                    state_next = ST_APKT;
                end
                else if (scan_reg < fill_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = scan_reg[uhct_pkg::IDX_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                else if (fill_reg == uhct_pkg::FILL_FULL)
                begin
                    full_next  = 1'b1;
                    slot_next  = '0;
                    pk_next    = '0;
                    by_next    = '0;
                    state_next = ST_TPKT;
                end
                else
                begin
                    new_next   = 1'b1;
                    slot_next  = fill_reg[uhct_pkg::IDX_W-1:0];
                    state_next = ST_APKT;
                end
            end
            ST_APKT:
            begin
                pk_next    = add_sum;
                state_next = ST_ABYTE;
            end
            ST_ABYTE:
            begin
                by_next    = add_sum;
                state_next = ST_TPKT;
            end
            ST_TPKT:
            begin
                tpkt_next  = add_sum;
                cnt_we     = !full_reg;
                key_we     = new_reg;
                if (new_reg)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_TBYTE;
            end
            ST_TBYTE:
            begin
                tbyte_next = add_sum;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            tpkt_reg     <= '0;
            tbyte_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= rd_valid_next;
            tpkt_reg     <= tpkt_next;
            tbyte_reg    <= tbyte_next;
        end
    end

    // packet payload and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_ip_reg  <= ip_address;
            key_mac_reg <= mac_address;
            len_reg     <= frame_length;
        end
        rd_idx_reg <= rd_idx_next;
        slot_reg   <= slot_next;
        new_reg    <= new_next;
        full_reg   <= full_next;
        pk_reg     <= pk_next;
        by_reg     <= by_next;
    end

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            ip_mem[slot_reg]  <= key_ip_reg;
            mac_mem[slot_reg] <= key_mac_reg;
        end
        if (cnt_we)
        begin
            pkt_mem[slot_reg]  <= pk_reg;
            byte_mem[slot_reg] <= by_reg;
        end
        if (rd_en)
        begin
            ip_q   <= ip_mem[scan_reg[uhct_pkg::IDX_W-1:0]];
            mac_q  <= mac_mem[scan_reg[uhct_pkg::IDX_W-1:0]];
            pkt_q  <= pkt_mem[scan_reg[uhct_pkg::IDX_W-1:0]];
            byte_q <= byte_mem[scan_reg[uhct_pkg::IDX_W-1:0]];
        end
    end

    assign done          = (state_reg == ST_DONE);
    assign entry_index   = uhct_pkg::OIDX_W'(slot_reg);
    assign was_new       = new_reg;
    assign table_full    = full_reg;
    assign entry_packets = pk_reg;
    assign entry_bytes   = by_reg;
    assign hosts_seen    = uhct_pkg::OFILL_W'(fill_reg);
    assign packets_seen  = tpkt_reg;
    assign bytes_seen    = tbyte_reg;

    `UHCT_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= uhct_pkg::FILL_FULL,
        "host fill count beyond table depth")
    `UHCT_ASSERT_IMP(a_full_only_when_full, done && table_full,
        (fill_reg == uhct_pkg::FILL_FULL) && !was_new, "table full flag without full table")
    `UHCT_ASSERT_NXT(a_done_then_idle, done, !busy && !done,
        "result strobe not followed by idle")
    `UHCT_ASSERT_NXT(a_start_goes_busy, start && !busy, busy,
        "accepted packet did not start a search")

endmodule
